@@ rtl/dlts_pkg.sv @@
package dlts_pkg;

  localparam int unsigned TimersDef  = 16;
  localparam int unsigned MaxResults = 16;
  localparam int unsigned NW         = $clog2(MaxResults + 1);

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_ARM  = 1'b1;

  localparam logic [1:0] KIND_FIRED = 2'd0;
  localparam logic [1:0] KIND_ACK   = 2'd1;
  localparam logic [1:0] KIND_IDLE  = 2'd2;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  timer_id;
    logic [15:0] delay;
    logic [15:0] period;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  fired_id;
    logic [15:0] remaining;
    logic        status;
    logic        last;
  } res_t;

  // controller -> datapath
  typedef struct packed {
    logic       take;
    logic       walk_clr;
    logic       find_step;
    logic       found_set;
    logic       ins_step;
    logic       do_insert;
    logic       rm_en;
    logic       rm_head;
    logic       dec_head;
    logic       pop_cap;
    logic       out_load;
    logic [1:0] out_kind;
    logic       out_status;
    logic       out_last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_arm;
    logic walk_done;
    logic match;
    logic ins_stop;
    logic found;
    logic full;
    logic delay_zero;
    logic cnt_nz;
    logic head_zero;
    logic head_per_zero;
    logic out_busy;
  } sts_t;

endpackage

@@ rtl/dlts_if.sv @@
interface dlts_item_if;
  import dlts_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dlts_res_if;
  import dlts_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/dlts_dp.sv @@
module dlts_dp #(
  parameter int unsigned TIMERS = dlts_pkg::TimersDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  dlts_pkg::item_t in_data_i,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output dlts_pkg::res_t  out_data_o,
  input  dlts_pkg::cmd_t  cmd_i,
  output dlts_pkg::sts_t  sts_o
);
  import dlts_pkg::*;

  localparam int unsigned IW = $clog2(TIMERS);
  localparam int unsigned CW = $clog2(TIMERS + 1);

  logic [7:0]    id_q  [TIMERS];
  logic [15:0]   dl_q  [TIMERS];
  logic [15:0]   per_q [TIMERS];
  logic [CW-1:0] count_q;

  item_t         item_q;
  logic [CW-1:0] p_q;
  logic [15:0]   base_q;
  logic          found_q;
  logic [IW-1:0] pos_q;
  logic [15:0]   rem_q;
  logic [7:0]    pop_id_q;
  logic [15:0]   pop_per_q;
  logic          out_valid_q;
  res_t          out_q;

  logic [IW-1:0] pidx, rp, rnext;
  logic [15:0]   cur_dl, key, dnew;
  logic [16:0]   walk_sum, rm_sum;
  logic [15:0]   walk_sat, rm_sat;
  logic [7:0]    ins_id;
  logic [15:0]   ins_per;

  assign pidx     = p_q[IW-1:0];
  assign cur_dl   = dl_q[pidx];
  assign walk_sum = {1'b0, base_q} + {1'b0, cur_dl};
  assign walk_sat = walk_sum[16] ? 16'hFFFF : walk_sum[15:0];
  assign key      = item_q.cmd == CMD_ARM ? item_q.delay : pop_per_q;
  assign ins_id   = item_q.cmd == CMD_ARM ? item_q.timer_id : pop_id_q;
  assign ins_per  = item_q.cmd == CMD_ARM ? item_q.period : pop_per_q;
  assign dnew     = key - base_q;

  assign rp     = cmd_i.rm_head ? '0 : pos_q;
  assign rnext  = (32'(rp) == TIMERS - 1) ? rp : rp + IW'(1);
  assign rm_sum = {1'b0, dl_q[rp]} + {1'b0, dl_q[rnext]};
  assign rm_sat = rm_sum[16] ? 16'hFFFF : rm_sum[15:0];

  always_comb begin
    sts_o.in_arm        = in_data_i.cmd == CMD_ARM;
    sts_o.walk_done     = p_q == count_q;
    sts_o.match         = id_q[pidx] == item_q.timer_id;
    sts_o.ins_stop      = {1'b0, key} < walk_sum;
    sts_o.found         = found_q;
    sts_o.full          = 32'(count_q) == TIMERS;
    sts_o.delay_zero    = item_q.delay == '0;
    sts_o.cnt_nz        = count_q != '0;
    sts_o.head_zero     = dl_q[0] == '0;
    sts_o.head_per_zero = per_q[0] == '0;
    sts_o.out_busy      = out_valid_q && !out_ready_i;
  end

  // entry table: one shift or one update per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.dec_head) begin
      if (count_q != '0 && dl_q[0] != '0) begin
        dl_q[0] <= dl_q[0] - 16'd1;
      end
    end else if (cmd_i.rm_en) begin
      for (int i = 0; i < TIMERS - 1; i++) begin
        if (i >= int'(rp)) begin
          id_q[i]  <= id_q[i+1];
          // removed delta folds into its successor
          dl_q[i]  <= (i == int'(rp)) ? rm_sat : dl_q[i+1];
          per_q[i] <= per_q[i+1];
        end
      end
    end else if (cmd_i.do_insert) begin
      for (int i = 1; i < TIMERS; i++) begin
        if (i > int'(pidx)) begin
          id_q[i]  <= id_q[i-1];
          per_q[i] <= per_q[i-1];
          dl_q[i]  <= (i == int'(pidx) + 1) ? dl_q[i-1] - dnew : dl_q[i-1];
        end
      end
      id_q[pidx]  <= ins_id;
      dl_q[pidx]  <= dnew;
      per_q[pidx] <= ins_per;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.rm_en) begin
        count_q <= count_q - CW'(1);
      end else if (cmd_i.do_insert) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.take) begin
        found_q <= 1'b0;
      end else if (cmd_i.found_set) begin
        found_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && in_valid_i) begin
      item_q <= in_data_i;
      rem_q  <= '0;
    end else if (cmd_i.found_set) begin
      rem_q <= walk_sat;
      pos_q <= pidx;
    end
    if (cmd_i.walk_clr) begin
      p_q    <= '0;
      base_q <= '0;
    end else if (cmd_i.find_step) begin
      p_q    <= p_q + CW'(1);
      base_q <= walk_sat;
    end else if (cmd_i.ins_step) begin
      p_q    <= p_q + CW'(1);
      base_q <= walk_sum[15:0];
    end
    if (cmd_i.pop_cap) begin
      pop_id_q  <= id_q[0];
      pop_per_q <= per_q[0];
    end
    if (cmd_i.out_load) begin
      out_q.kind      <= cmd_i.out_kind;
      out_q.status    <= cmd_i.out_status;
      out_q.last      <= cmd_i.out_last;
      out_q.fired_id  <= cmd_i.out_kind == KIND_FIRED ? pop_id_q :
                         cmd_i.out_kind == KIND_ACK ? item_q.timer_id : 8'd0;
      out_q.remaining <= cmd_i.out_kind == KIND_ACK ? rem_q : 16'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/dlts_ctrl.sv @@
module dlts_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dlts_pkg::sts_t sts_i,
  output dlts_pkg::cmd_t cmd_o
);
  import dlts_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_FIND     = 3'd1;
  localparam logic [2:0] S_ARM_DO   = 3'd2;
  localparam logic [2:0] S_INS_WALK = 3'd3;
  localparam logic [2:0] S_TICK_CHK = 3'd4;
  localparam logic [2:0] S_EMIT     = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [1:0]    kind_q, kind_d;
  logic          status_q, status_d;
  logic [NW-1:0] n_q, n_d;
  logic          more;

  assign more       = sts_i.cnt_nz && sts_i.head_zero && 32'(n_q) != MaxResults;
  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d  = state_q;
    kind_d   = kind_q;
    status_d = status_q;
    n_d      = n_q;
    cmd_o    = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.take = 1'b1;
        if (in_valid_i) begin
          n_d      = '0;
          status_d = ST_OK;
          if (sts_i.in_arm) begin
            cmd_o.walk_clr = 1'b1;
            state_d        = S_FIND;
          end else begin
            cmd_o.dec_head = 1'b1;
            state_d        = S_TICK_CHK;
          end
        end
      end
      S_FIND: begin
        if (sts_i.walk_done) begin
          state_d = S_ARM_DO;
        end else if (sts_i.match) begin
          cmd_o.found_set = 1'b1;
          state_d         = S_ARM_DO;
        end else begin
          cmd_o.find_step = 1'b1;
        end
      end
      S_ARM_DO: begin
        kind_d = KIND_ACK;
        if (sts_i.delay_zero) begin
          cmd_o.rm_en = sts_i.found;
          state_d     = S_EMIT;
        end else if (!sts_i.found && sts_i.full) begin
          status_d = ST_FULL;
          state_d  = S_EMIT;
        end else begin
          cmd_o.rm_en    = sts_i.found;
          cmd_o.walk_clr = 1'b1;
          state_d        = S_INS_WALK;
        end
      end
      S_INS_WALK: begin
        if (sts_i.walk_done || sts_i.ins_stop) begin
          cmd_o.do_insert = 1'b1;
          state_d         = S_EMIT;
        end else begin
          cmd_o.ins_step = 1'b1;
        end
      end
      S_TICK_CHK: begin
        if (more) begin
          // pop the head; reload it when periodic
          cmd_o.rm_en    = 1'b1;
          cmd_o.rm_head  = 1'b1;
          cmd_o.pop_cap  = 1'b1;
          cmd_o.walk_clr = 1'b1;
          kind_d         = KIND_FIRED;
          n_d            = n_q + NW'(1);
          state_d        = sts_i.head_per_zero ? S_EMIT : S_INS_WALK;
        end else begin
          kind_d  = KIND_IDLE;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_kind   = kind_q;
          cmd_o.out_status = status_q;
          cmd_o.out_last   = kind_q != KIND_FIRED || !more;
          state_d          = cmd_o.out_last ? S_IDLE : S_TICK_CHK;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      kind_q   <= KIND_IDLE;
      status_q <= ST_OK;
      n_q      <= '0;
    end else begin
      state_q  <= state_d;
      kind_q   <= kind_d;
      status_q <= status_d;
      n_q      <= n_d;
    end
  end

endmodule

@@ rtl/delta_list_timer_scheduler.sv @@
// Delta-list timer scheduler. Holds up to TIMERS timers sorted by due time;
// each entry stores its id, reload period and the delta to its predecessor.
// An arm walks the list once to find the id (one entry per cycle), then,
// unless it cancels the timer or the table is full, once more to find its
// insertion point. A tick decrements a nonzero head delta, then pops each due
// timer, at most MaxResults per tick, and for each periodic timer that
// fires walks the list once more to reinsert it. A stalled result register
// adds its wait. The list walks through the shared entry table set the rate.
// One item is processed at a time; the result register lets the last result
// wait while the next item is taken.
module delta_list_timer_scheduler #(
  parameter int unsigned TIMERS = dlts_pkg::TimersDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dlts_item_if.sink  in_i,
  dlts_res_if.source out_o
);
  import dlts_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dlts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dlts_dp #(
    .TIMERS (TIMERS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_data_i   (in_i.data),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

@@ sim/delta_list_timer_scheduler_test.sv @@
`timescale 1ns / 1ps

module delta_list_timer_scheduler_test;
  import dlts_pkg::*;

  localparam int unsigned Slots = TimersDef;
  localparam int unsigned QuietLimit = 20000;

  class timer_scoreboard;
    logic [7:0]  ids[Slots];
    logic [15:0] deltas[Slots];
    logic [15:0] periods[Slots];
    int unsigned count;
    res_t        pending[$];
    int unsigned errors;

    function new();
      count = 0;
      errors = 0;
    endfunction

    function int locate(logic [7:0] id);
      for (int i = 0; i < count; i++) if (ids[i] == id) return i;
      return -1;
    endfunction

    function logic [15:0] due_at(int pos);
      int unsigned sum;
      sum = 0;
      for (int i = 0; i <= pos; i++) sum += deltas[i];
      return (sum > 65535) ? 16'hffff : sum[15:0];
    endfunction

    function void unlink(int pos);
      int unsigned s;
      if (pos + 1 < count) begin
        s = deltas[pos + 1] + deltas[pos];
        deltas[pos + 1] = (s > 65535) ? 16'hffff : s[15:0];
      end
      for (int i = pos; i + 1 < count; i++) begin
        ids[i] = ids[i + 1];
        deltas[i] = deltas[i + 1];
        periods[i] = periods[i + 1];
      end
      count--;
    endfunction

    function void link(logic [7:0] id, logic [15:0] delay, logic [15:0] per);
      int unsigned base, nb;
      int pos;
      logic [15:0] d;
      base = 0;
      pos = 0;
      if (count >= Slots) return;
      while (pos < count) begin
        nb = base + deltas[pos];
        if (delay < nb) break;
        base = nb;
        pos++;
      end
      d = delay - base[15:0];
      for (int i = count; i > pos; i--) begin
        ids[i] = ids[i - 1];
        deltas[i] = deltas[i - 1];
        periods[i] = periods[i - 1];
      end
      count++;
      if (pos + 1 < count) deltas[pos + 1] = deltas[pos + 1] - d;
      ids[pos] = id;
      deltas[pos] = d;
      periods[pos] = per;
    endfunction

    function void push(logic [1:0] kind, logic [7:0] id, logic [15:0] rem, logic st);
      res_t r;
      r.kind = kind;
      r.fired_id = id;
      r.remaining = rem;
      r.status = st;
      r.last = 1'b0;
      pending.push_back(r);
    endfunction

    function void note_item(item_t it);
      int pos, n;
      logic [15:0] rem;
      logic st;
      logic [7:0] fid;
      logic [15:0] per;
      n = 0;
      if (it.cmd == CMD_ARM) begin
        pos = locate(it.timer_id);
        rem = (pos >= 0) ? due_at(pos) : 16'd0;
        st = ST_OK;
        if (it.delay == 0) begin
          if (pos >= 0) unlink(pos);
        end else if (pos < 0 && count >= Slots) begin
          st = ST_FULL;
        end else begin
          if (pos >= 0) unlink(pos);
          link(it.timer_id, it.delay, it.period);
        end
        push(KIND_ACK, it.timer_id, rem, st);
      end else begin
        if (count > 0 && deltas[0] > 0) deltas[0]--;
        while (count > 0 && deltas[0] == 0 && n < MaxResults) begin
          fid = ids[0];
          per = periods[0];
          unlink(0);
          if (per > 0) link(fid, per, per);
          push(KIND_FIRED, fid, 16'd0, ST_OK);
          n++;
        end
        if (n == 0) push(KIND_IDLE, 8'd0, 16'd0, ST_OK);
      end
      pending[pending.size() - 1].last = 1'b1;
    endfunction

    function void check_result(res_t got);
      res_t exp;
      if (pending.size() == 0) begin
        $error("unexpected result kind=%0d id=%0d", got.kind, got.fired_id);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.kind !== exp.kind) begin
        $error("kind: expected %0d, got %0d", exp.kind, got.kind); errors++;
      end
      if (got.fired_id !== exp.fired_id) begin
        $error("fired_id: expected %0d, got %0d", exp.fired_id, got.fired_id); errors++;
      end
      if (got.remaining !== exp.remaining) begin
        $error("remaining: expected %0d, got %0d", exp.remaining, got.remaining); errors++;
      end
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status); errors++;
      end
      if (got.last !== exp.last) begin
        $error("last: expected %0d, got %0d", exp.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;

  timer_scoreboard board = new();

  dlts_item_if in_ch();
  dlts_res_if  out_ch();

  delta_list_timer_scheduler dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // drive ready, check results, watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) board.check_result(out_ch.data);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // valid stays high after a transfer until the next item or an idle gap
  task automatic send_item(logic cmd, logic [7:0] id, logic [15:0] delay, logic [15:0] per);
    item_t it;
    it.cmd = cmd;
    it.timer_id = id;
    it.delay = delay;
    it.period = per;
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    board.note_item(it);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  // mostly small ids so arms hit armed timers and the table fills up
  task automatic random_items(int unsigned n);
    logic [7:0] id;
    logic [15:0] dl, per;
    for (int i = 0; i < n; i++) begin
      id = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(23));
      case ($urandom_range(9))
        0: dl = 16'd0;
        1: dl = 16'($urandom);
        default: dl = 16'($urandom_range(1, 12));
      endcase
      case ($urandom_range(5))
        0: per = 16'($urandom);
        1, 2: per = 16'($urandom_range(1, 8));
        default: per = 16'd0;
      endcase
      send_item($urandom_range(9) < 5, id, dl, per);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: empty tick, cancel unknown, extremes, ties, overflow of the table
    send_item(CMD_TICK, 8'hff, 16'hffff, 16'hffff);
    send_item(CMD_ARM, 8'h00, 16'd0, 16'd0);
    send_item(CMD_ARM, 8'hff, 16'hffff, 16'hffff);
    send_item(CMD_ARM, 8'h01, 16'd2, 16'd0);
    send_item(CMD_ARM, 8'h02, 16'd2, 16'd1);
    send_item(CMD_ARM, 8'h03, 16'd5, 16'd0);
    send_item(CMD_ARM, 8'hff, 16'd0, 16'd0);
    send_item(CMD_ARM, 8'h01, 16'd0, 16'd0);
    send_item(CMD_ARM, 8'h03, 16'd1, 16'haaaa);
    send_item(CMD_TICK, 8'h00, 16'd0, 16'd0);
    send_item(CMD_TICK, 8'h00, 16'd0, 16'd0);
    send_item(CMD_TICK, 8'h00, 16'd0, 16'd0);
    for (int i = 0; i < 16; i++) send_item(CMD_ARM, 8'(8'h10 + i), 16'd1, 16'd0);
    send_item(CMD_ARM, 8'h55, 16'd3, 16'd0);
    send_item(CMD_ARM, 8'h10, 16'd4, 16'h5555);
    send_item(CMD_TICK, 8'h00, 16'd0, 16'd0);
    drain();
    send_idle_pct = 86;
    random_items(60);
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 86;
    random_items(60);
    send_idle_pct = 15;
    recv_stall_pct = 15;
    random_items(60);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_items(20);
    drain();
    repeat (200) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
